@@ hdl/scu_pkg.sv @@
// Shared types, constants and the rejection test for the unit-square segment clipper.
// Used by scu_clip_step and segment_clip_unit_square_top; depends on nothing else.
`default_nettype none

package scu_pkg;

  localparam int CW = 32;          // coordinate width, signed Q16.16
  localparam int DW = CW + 1;      // width of a coordinate difference
  localparam int QW = CW;          // quotient bits of one interpolation
  localparam int NSTEPS = 8;       // edge clips, in fixed order
  localparam logic signed [CW-1:0] FX_ZERO = '0;
  localparam logic signed [CW-1:0] FX_ONE = 32'sd65536;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
  } seg_t;

  typedef struct packed {
    logic rej;
    seg_t cur;
    seg_t org;
  } item_t;

  // True when both endpoints lie beyond the same edge of the square.
  function automatic logic outside(seg_t s);
    outside = (s.x1 < FX_ZERO && s.x2 < FX_ZERO) ||
              (s.x1 > FX_ONE && s.x2 > FX_ONE) ||
              (s.y1 < FX_ZERO && s.y2 < FX_ZERO) ||
              (s.y1 > FX_ONE && s.y2 > FX_ONE);
  endfunction

endpackage

`default_nettype wire

@@ hdl/scu_clip_step.sv @@
// One edge clip of the segment clipper: condition test, multiply, a bit-per-stage
// divider and the write-back with a fresh rejection test. Depends on scu_pkg.
`default_nettype none

module scu_clip_step #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  scu_pkg::item_t in_item,
  output logic           out_vld,
  output scu_pkg::item_t out_item
);

  localparam bit AXIS_Y = (STEP >= 4);
  localparam bit SECOND = ((STEP % 2) == 1);
  localparam bit HIGH = (((STEP / 2) % 2) == 1);
  localparam logic signed [scu_pkg::CW-1:0] EDGE =
    HIGH ? scu_pkg::FX_ONE : scu_pkg::FX_ZERO;
  localparam int CW = scu_pkg::CW;
  localparam int DW = scu_pkg::DW;
  localparam int QW = scu_pkg::QW;

  typedef struct packed {
    scu_pkg::item_t       item;
    logic                 act;
    logic                 neg;
    logic                 cz;
    logic signed [CW-1:0] refv;
  } ctl_t;

  // Operand selection for this edge.
  logic signed [CW-1:0] e1_w, e2_w, o1_w, o2_w, ep_w;
  logic signed [DW-1:0] a_w, b_w, c_w;
  logic [DW-1:0]        am_w, bm_w, cm_w;
  logic                 cond_w;

  always_comb begin
    if (AXIS_Y) begin
      e1_w = in_item.cur.y1;
      e2_w = in_item.cur.y2;
      o1_w = in_item.cur.x1;
      o2_w = in_item.cur.x2;
    end else begin
      e1_w = in_item.cur.x1;
      e2_w = in_item.cur.x2;
      o1_w = in_item.cur.y1;
      o2_w = in_item.cur.y2;
    end
    ep_w = SECOND ? e2_w : e1_w;
    cond_w = HIGH ? (ep_w > EDGE) : (ep_w < scu_pkg::FX_ZERO);
    a_w = {e2_w[CW-1], e2_w} - {EDGE[CW-1], EDGE};
    b_w = {o2_w[CW-1], o2_w} - {o1_w[CW-1], o1_w};
    c_w = {e2_w[CW-1], e2_w} - {e1_w[CW-1], e1_w};
    am_w = a_w[DW-1] ? DW'(-a_w) : DW'(a_w);
    bm_w = b_w[DW-1] ? DW'(-b_w) : DW'(b_w);
    cm_w = c_w[DW-1] ? DW'(-c_w) : DW'(c_w);
  end

  // Operand stage.
  logic          va_r;
  ctl_t          ca_r;
  logic [DW-1:0] am_r, bm_r, cm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_vld;
    end
    ca_r.item <= in_item;
    ca_r.act <= !in_item.rej && cond_w;
    ca_r.neg <= a_w[DW-1] ^ b_w[DW-1] ^ c_w[DW-1];
    ca_r.cz <= (c_w == '0);
    ca_r.refv <= o2_w;
    am_r <= am_w;
    bm_r <= bm_w;
    cm_r <= cm_w;
  end

  // Product stage and divider pipeline; index k holds k quotient bits.
  logic          vld_r [QW+1];
  ctl_t          ctl_r [QW+1];
  logic [DW-1:0] dv_r  [QW+1];
  logic [DW-1:0] rem_r [QW+1];
  logic [QW-1:0] lq_r  [QW+1];
  logic [2*DW-1:0] prod_w;

  assign prod_w = am_r * bm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= va_r;
    end
    ctl_r[0] <= ca_r;
    dv_r[0] <= cm_r;
    rem_r[0] <= prod_w[QW+DW-1:QW];
    lq_r[0] <= prod_w[QW-1:0];
  end

  genvar k;
  for (k = 0; k < QW; k++) begin : g_div
    logic [DW:0] t_w, s_w;
    logic        ge_w;
    assign t_w = {rem_r[k], lq_r[k][QW-1]};
    assign s_w = t_w - {1'b0, dv_r[k]};
    assign ge_w = (t_w >= {1'b0, dv_r[k]});
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      ctl_r[k+1] <= ctl_r[k];
      dv_r[k+1] <= dv_r[k];
      rem_r[k+1] <= ge_w ? s_w[DW-1:0] : t_w[DW-1:0];
      lq_r[k+1] <= {lq_r[k][QW-2:0], ge_w};
    end
  end

  // Write-back: move the endpoint onto the edge and test for rejection again.
  ctl_t                 cf_w;
  logic [CW+1:0]        qs_w;
  logic [CW+1:0]        nw_w;
  logic signed [CW-1:0] newo_w;
  scu_pkg::item_t       it_nxt;

  always_comb begin
    cf_w = ctl_r[QW];
    qs_w = cf_w.neg ? (CW+2)'(-{2'b00, lq_r[QW]}) : {2'b00, lq_r[QW]};
    nw_w = {cf_w.refv[CW-1], cf_w.refv[CW-1], cf_w.refv} - qs_w;
    newo_w = cf_w.cz ? cf_w.refv : nw_w[CW-1:0];
    it_nxt = cf_w.item;
    if (cf_w.act) begin
      if (AXIS_Y) begin
        if (SECOND) begin
          it_nxt.cur.y2 = EDGE;
          it_nxt.cur.x2 = newo_w;
        end else begin
          it_nxt.cur.y1 = EDGE;
          it_nxt.cur.x1 = newo_w;
        end
      end else begin
        if (SECOND) begin
          it_nxt.cur.x2 = EDGE;
          it_nxt.cur.y2 = newo_w;
        end else begin
          it_nxt.cur.x1 = EDGE;
          it_nxt.cur.y1 = newo_w;
        end
      end
    end
    it_nxt.rej = cf_w.item.rej || scu_pkg::outside(it_nxt.cur);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld_r[QW];
    end
    out_item <= it_nxt;
  end

  // The edge distance never exceeds the divisor, which bounds the quotient.
  a_ratio_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (va_r && ca_r.act) |-> (am_r <= cm_r))
    else $error("edge distance exceeds divisor on a live clip");

  // A live clip never meets a zero divisor.
  a_no_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && ctl_r[0].act) |-> !ctl_r[0].cz)
    else $error("zero divisor on a live clip");

  // The quotient fits the divider: the partial remainder starts below the divisor.
  a_rem_start: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && ctl_r[0].act) |-> (rem_r[0] < dv_r[0]))
    else $error("quotient overflows the divider");

endmodule

`default_nettype wire

@@ hdl/segment_clip_unit_square_top.sv @@
// Top level of the unit-square segment clipper: input register, a clip step
// per endpoint and edge, result register. Depends on scu_pkg and scu_clip_step.
`default_nettype none

// This block clips one line segment, given as two endpoints in signed Q16.16
// (65536 is 1.0), to the unit square. A transaction is accepted on each rising
// edge where start is high and busy is low; busy stays low, so a new segment
// may be presented on every clock cycle. Each segment is fully pipelined: an
// input register with the first rejection test, then eight clip steps (x1 < 0,
// x2 < 0, x1 > 1, x2 > 1, y1 < 0, y2 < 0, y1 > 1, y2 > 1), each 35 stages deep
// (operand setup, one 33 by 33 multiply, a 32-stage divider that retires one
// quotient bit per stage, and the write-back with a fresh rejection test), then
// the result register. The result of a transaction is shown with out_valid high
// for exactly one cycle, and results leave in the order the segments came in.
// The receiver cannot hold results off, so it must take each one in the cycle
// it is shown. When out_visible is low the segment was rejected and the four
// coordinate outputs repeat the input endpoints; otherwise they give the clipped
// endpoints. Quotients of the interpolation truncate toward zero.

module segment_clip_unit_square_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  output logic        out_valid,
  output logic        out_visible,
  output logic signed [31:0] out_clip_start_x,
  output logic signed [31:0] out_clip_start_y,
  output logic signed [31:0] out_clip_end_x,
  output logic signed [31:0] out_clip_end_y
);

  localparam int NS = scu_pkg::NSTEPS;

  // The pipeline never stalls, so the block is always ready for a transaction.
  assign busy = 1'b0;

  logic           vld_w  [NS+1];
  scu_pkg::item_t item_w [NS+1];

  // Input register: capture the segment and run the first rejection test.
  scu_pkg::seg_t  seg_w;
  logic           v0_r;
  scu_pkg::item_t i0_r;

  always_comb begin
    seg_w.x1 = in_start_x;
    seg_w.y1 = in_start_y;
    seg_w.x2 = in_end_x;
    seg_w.y2 = in_end_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
    i0_r.rej <= scu_pkg::outside(seg_w);
    i0_r.cur <= seg_w;
    i0_r.org <= seg_w;
  end

  assign vld_w[0] = v0_r;
  assign item_w[0] = i0_r;

  // The edge clips, one per endpoint and edge, in the fixed order given above.
  genvar s;
  for (s = 0; s < NS; s++) begin : g_step
    scu_clip_step #(
      .STEP(s)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (vld_w[s]),
      .in_item (item_w[s]),
      .out_vld (vld_w[s+1]),
      .out_item(item_w[s+1])
    );
  end

  // Result register: a rejected segment reports its original endpoints.
  scu_pkg::item_t fin_w;
  scu_pkg::seg_t  res_w;

  always_comb begin
    fin_w = item_w[NS];
    res_w = fin_w.rej ? fin_w.org : fin_w.cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_w[NS];
    end
    out_visible <= !fin_w.rej;
    out_clip_start_x <= res_w.x1;
    out_clip_start_y <= res_w.y1;
    out_clip_end_x <= res_w.x2;
    out_clip_end_y <= res_w.y2;
  end

  // A visible result lies entirely within the unit square.
  a_visible_in_square: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_visible) |->
      (out_clip_start_x >= scu_pkg::FX_ZERO && out_clip_start_x <= scu_pkg::FX_ONE &&
       out_clip_start_y >= scu_pkg::FX_ZERO && out_clip_start_y <= scu_pkg::FX_ONE &&
       out_clip_end_x >= scu_pkg::FX_ZERO && out_clip_end_x <= scu_pkg::FX_ONE &&
       out_clip_end_y >= scu_pkg::FX_ZERO && out_clip_end_y <= scu_pkg::FX_ONE))
    else $error("visible segment leaves the unit square");

endmodule

`default_nettype wire
